// ----- src/wsp_pkg.sv -----
// Shared types and constants for the world-to-screen projection pipeline.
// No dependencies; used by the top level, the viewport mapper and the checker.
package wsp_pkg;

    // One world point, signed fixed point coordinates
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } t_world;

    // One projected pixel
    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               visible;
    } t_screen;

    // Control that travels alongside the mapper lanes
    typedef struct packed {
        logic valid;
        logic vis;
    } t_map_ctl;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_LO  = 4'd0,
        CFG_ROW0_HI  = 4'd1,
        CFG_ROW1_LO  = 4'd2,
        CFG_ROW1_HI  = 4'd3,
        CFG_ROW3_LO  = 4'd4,
        CFG_ROW3_HI  = 4'd5,
        CFG_ORIGIN   = 4'd6,
        CFG_EXTENT   = 4'd7
    } t_cfg_reg;

    // Quotient bits resolved by the divider; larger magnitudes saturate anyway
    localparam int QUO_BITS = 17;

    // Cycles from an accepted item to its result strobe
    localparam int PIPE_LAT = 9 + QUO_BITS;

endpackage

// ----- src/wsp_map.sv -----
// Viewport mapper: floor(ext*n/d) by a pipelined restoring divider, plus origin and clamp.
// Depends on wsp_pkg for t_map_ctl, t_screen and QUO_BITS.
module wsp_map #(
    parameter int NUM_W = 67,
    parameter int DEN_W = 51
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  wsp_pkg::t_map_ctl        i_ctl,
    input  logic signed [NUM_W-1:0]  i_num [2],
    input  logic        [DEN_W-1:0]  i_den,
    input  logic signed [15:0]       i_origin [2],
    output logic                     o_done,
    output wsp_pkg::t_screen         o_result
);
    localparam int QB = wsp_pkg::QUO_BITS;
    localparam int MW = NUM_W + 1;

    // stage 0: magnitude and clamp flag; stages 1..QB: one quotient bit each
    logic [QB:0]       r_vld;
    logic [QB:0]       r_vis;
    logic [DEN_W-1:0]  r_den [QB+1];
    logic [MW-1:0]     r_rem [2][QB+1];
    logic [QB-1:0]     r_q   [2][QB+1];
    logic [1:0]        r_neg [QB+1];
    logic [1:0]        r_sat [QB+1];
    logic              r_out_vld;
    wsp_pkg::t_screen  r_out;

    logic [MW-1:0]         n_m   [2];
    logic [1:0]            n_sat;
    logic [MW-1:0]         n_rem [2][1:QB];
    logic                  n_bit [2][1:QB];
    logic signed [QB+2:0]  n_tot [2];
    logic signed [15:0]    n_pix [2];

    // magnitude: num, or d-1-num for a negative num (floor toward minus infinity)
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_num[l][NUM_W-1]) begin
                n_m[l] = MW'(i_den) - MW'(1) - $unsigned(MW'(i_num[l]));
            end else begin
                n_m[l] = $unsigned(MW'(i_num[l]));
            end
            n_sat[l] = n_m[l] >= (MW'(i_den) << QB);
        end
    end

    // restoring steps
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int s = 1; s <= QB; s++) begin
                n_bit[l][s] = r_rem[l][s-1] >= (MW'(r_den[s-1]) << (QB - s));
                n_rem[l][s] = n_bit[l][s] ?
                              r_rem[l][s-1] - (MW'(r_den[s-1]) << (QB - s)) :
                              r_rem[l][s-1];
            end
        end
    end

    // sign, origin and clamp to 16 bits
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic signed [QB+1:0] mag;
            mag = r_sat[QB][l] ? (QB+2)'(1) <<< QB : $signed({2'b00, r_q[l][QB]});
            if (r_neg[QB][l]) begin
                mag = -mag;
            end
            n_tot[l] = (QB+3)'(i_origin[l]) + (QB+3)'(mag);
            if (n_tot[l] > (QB+3)'(32767)) begin
                n_pix[l] = 16'sh7fff;
            end else if (n_tot[l] < -(QB+3)'(32768)) begin
                n_pix[l] = -16'sh8000;
            end else begin
                n_pix[l] = n_tot[l][15:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[QB-1:0], i_ctl.valid};
            r_out_vld <= r_vld[QB];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_vis[0] <= i_ctl.vis;
        r_den[0] <= i_den;
        for (int l = 0; l < 2; l++) begin
            r_rem[l][0] <= n_m[l];
            r_q[l][0]   <= '0;
            r_neg[0][l] <= i_num[l][NUM_W-1];
            r_sat[0][l] <= n_sat[l];
        end
        for (int s = 1; s <= QB; s++) begin
            r_vis[s] <= r_vis[s-1];
            r_den[s] <= r_den[s-1];
            r_neg[s] <= r_neg[s-1];
            r_sat[s] <= r_sat[s-1];
            for (int l = 0; l < 2; l++) begin
                r_rem[l][s] <= n_rem[l][s];
                r_q[l][s]   <= {r_q[l][s-1][QB-2:0], n_bit[l][s]};
            end
        end
        r_out.visible  <= r_vis[QB];
        r_out.screen_x <= r_vis[QB] ? n_pix[0] : '0;
        r_out.screen_y <= r_vis[QB] ? n_pix[1] : '0;
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

// ----- src/world_to_screen_projection.sv -----
// Top level of the world-to-screen projection: matrix rows, clip sums, viewport mapping.
// Depends on wsp_pkg and wsp_map.

// Takes one world point per clock and returns one pixel per point, in order
// (o_done strobes for one cycle with o_result). o_busy never rises, so points
// may be issued every cycle. The mapper's 17-step quotient pipeline follows
// the nine 32x32 products, the clip sums and the viewport-extent products.
// Configuration writes are always ready; the user must write only after the
// pipeline has drained so they take effect for points issued after that, as
// the block itself does not enforce it and applies them to points in flight.
module world_to_screen_projection #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  wsp_pkg::t_world                  i_item,
    output logic                             o_done,
    output wsp_pkg::t_screen                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                      i_cfg_data
);
    localparam int SW    = 66 - COORD_FRAC_BITS;   // clip sum width
    localparam int NW    = SW + 17;                // ext * numerator
    localparam int DW    = SW + 1;                 // denominator 2w
    localparam int PHW   = SW - 14;                // high partial product
    localparam logic signed [SW-1:0] W_MIN =
        SW'(((64'sd1 <<< COORD_FRAC_BITS) + 64'sd50) / 64'sd100);

    // configuration
    logic signed [31:0] r_mat [3][4];
    logic signed [15:0] r_origin [2];
    logic        [15:0] r_ext [2];

    // pipeline
    logic [6:0]          r_vld;
    logic signed [31:0]  r_in  [3];
    logic signed [63:0]  r_p   [3][3];
    logic signed [SW-1:0] r_sa [3];
    logic signed [SW-1:0] r_sb [3];
    logic signed [SW-1:0] r_c  [3];
    logic signed [SW:0]  r_n   [2];
    logic [DW-1:0]       r_den_n, r_den_pp, r_den_num;
    logic                r_vis_n, r_vis_pp, r_vis_num;
    logic [47:0]         r_pl  [2];
    logic signed [PHW-1:0] r_ph [2];
    logic signed [NW-1:0] r_num [2];

    wsp_pkg::t_map_ctl   map_ctl;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_ext[0]    <= '0;
            r_ext[1]    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wsp_pkg::CFG_ROW0_LO: begin
                    r_mat[0][0] <= i_cfg_data[31:0];
                    r_mat[0][1] <= i_cfg_data[63:32];
                end
                wsp_pkg::CFG_ROW0_HI: begin
                    r_mat[0][2] <= i_cfg_data[31:0];
                    r_mat[0][3] <= i_cfg_data[63:32];
                end
                wsp_pkg::CFG_ROW1_LO: begin
                    r_mat[1][0] <= i_cfg_data[31:0];
                    r_mat[1][1] <= i_cfg_data[63:32];
                end
                wsp_pkg::CFG_ROW1_HI: begin
                    r_mat[1][2] <= i_cfg_data[31:0];
                    r_mat[1][3] <= i_cfg_data[63:32];
                end
                wsp_pkg::CFG_ROW3_LO: begin
                    r_mat[2][0] <= i_cfg_data[31:0];
                    r_mat[2][1] <= i_cfg_data[63:32];
                end
                wsp_pkg::CFG_ROW3_HI: begin
                    r_mat[2][2] <= i_cfg_data[31:0];
                    r_mat[2][3] <= i_cfg_data[63:32];
                end
                wsp_pkg::CFG_ORIGIN: begin
                    r_origin[0] <= i_cfg_data[15:0];
                    r_origin[1] <= i_cfg_data[31:16];
                end
                wsp_pkg::CFG_EXTENT: begin
                    r_ext[0] <= i_cfg_data[15:0];
                    r_ext[1] <= i_cfg_data[31:16];
                end
                default: begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_start};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        // input register
        r_in[0] <= i_item.world_x;
        r_in[1] <= i_item.world_y;
        r_in[2] <= i_item.world_z;
        // products
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_p[r][c] <= r_mat[r][c] * r_in[c];
            end
        end
        // floored terms, paired
        for (int r = 0; r < 3; r++) begin
            r_sa[r] <= SW'(r_p[r][0] >>> COORD_FRAC_BITS)
                     + SW'(r_p[r][1] >>> COORD_FRAC_BITS);
            r_sb[r] <= SW'(r_p[r][2] >>> COORD_FRAC_BITS) + SW'(r_mat[r][3]);
        end
        // clip x, y, w
        for (int r = 0; r < 3; r++) begin
            r_c[r] <= r_sa[r] + r_sb[r];
        end
        // numerators, denominator, visibility
        r_n[0]  <= (SW+1)'(r_c[2]) + (SW+1)'(r_c[0]);
        r_n[1]  <= (SW+1)'(r_c[2]) - (SW+1)'(r_c[1]);
        r_den_n <= $unsigned({r_c[2], 1'b0});
        r_vis_n <= r_c[2] >= W_MIN;
        // extent times numerator, split in two partial products
        for (int l = 0; l < 2; l++) begin
            r_pl[l] <= r_ext[l] * r_n[l][31:0];
            r_ph[l] <= $signed({1'b0, r_ext[l]}) * $signed(r_n[l][SW:32]);
        end
        r_den_pp <= r_den_n;
        r_vis_pp <= r_vis_n;
        // recombine
        for (int l = 0; l < 2; l++) begin
            r_num[l] <= (NW'(r_ph[l]) <<< 32) + NW'(r_pl[l]);
        end
        r_den_num <= r_den_pp;
        r_vis_num <= r_vis_pp;
    end

    assign map_ctl.valid = r_vld[6];
    assign map_ctl.vis   = r_vis_num;

    wsp_map #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (map_ctl),
        .i_num    (r_num),
        .i_den    (r_den_num),
        .i_origin (r_origin),
        .o_done   (o_done),
        .o_result (o_result)
    );

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- src/wsp_chk.sv -----
// Port-level checker for world_to_screen_projection, attached by bind.
// Depends on wsp_pkg for t_screen and PIPE_LAT.
module wsp_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             o_done,
    input wsp_pkg::t_screen o_result
);
    // every item yields its pixel after the fixed latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(wsp_pkg::PIPE_LAT) o_done)
        else $error("result missing after accepted item");

    // no pixel without an item issued the latency before
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, wsp_pkg::PIPE_LAT))
        else $error("result without matching item");

    // points that are not visible, such as those behind the viewer, report zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.visible) |->
            (o_result.screen_x == 16'sd0 && o_result.screen_y == 16'sd0))
        else $error("hidden point with nonzero pixel");

endmodule

bind world_to_screen_projection wsp_chk u_wsp_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
